// ===== rtl/assert_macros.svh =====
// assertion macros shared by the nearest fraction search modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define NFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked in the cycle after a trigger, outside reset
`define NFS_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/nfs_pkg.sv =====
// shared constants and types for the nearest fraction search block
package nfs_pkg;

    localparam int DENOM_CAP_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int VAL_W = 32;
    localparam int NUM_W = 23;
    localparam int DEN_W = 7;
    localparam int ERR_W = 16;

    localparam int LIMIT_RESET = 64;
    localparam int NUM_POS_MAX = (1 << (NUM_W - 1)) - 1;
    localparam int NUM_NEG_MAX = 1 << (NUM_W - 1);
    localparam int ERR_MAX     = (1 << ERR_W) - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/nfs_div.sv =====
// restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module nfs_div #(
    parameter int FRAC_BITS = nfs_pkg::FRAC_BITS_DEF,
    parameter int DW        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS-1:0] i_dividend,
    input  logic [DW-1:0]        i_divisor,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quotient
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_div;
    logic [FRAC_BITS-1:0] r_quo;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[FRAC_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `NFS_ASSERT(a_no_restart, !(i_start && r_busy), "divider started while busy")
    `NFS_ASSERT(a_cnt_range, !r_busy || (r_cnt <= CW'(FRAC_BITS - 1)),
                "divider step count out of range")

endmodule

// ===== rtl/nearest_fraction_search.sv =====
// nearest fraction search top level: bounded-denominator best fraction finder
//
//  port group   dir   signals                                    handshake
//  -----------  ----  -----------------------------------------  -----------------
//  input word   in    i_ratio_value                              i_valid / o_stall
//  result word  out   o_numerator, o_denominator, o_approx_error o_valid / i_stall
//  config       in    i_cfg_wr_data                              i_cfg_wr_en
//
// a word passes from acceptance to result valid in these steps: the shared multiply and compare
// tries each denominator from 1 up to the limit, the S_DIV_START state starts the divider, the
// serial divider forms the error, and the output register is loaded
// input is stalled from acceptance until the load, so a new word is not taken before the last
// result is loaded; a full output register under i_stall holds the load back further
// reset is synchronous, active low; the limit register returns to min(64, DENOM_CAP)
`include "assert_macros.svh"

module nearest_fraction_search #(
    parameter int DENOM_CAP = nfs_pkg::DENOM_CAP_DEF,
    parameter int FRAC_BITS = nfs_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [nfs_pkg::VAL_W-1:0] i_ratio_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [nfs_pkg::NUM_W-1:0] o_numerator,
    output logic        [nfs_pkg::DEN_W-1:0] o_denominator,
    output logic        [nfs_pkg::ERR_W-1:0] o_approx_error,
    input  logic                             i_cfg_wr_en,
    input  logic        [nfs_pkg::DEN_W-1:0] i_cfg_wr_data
);

    localparam int F    = FRAC_BITS;
    localparam int DW   = $clog2(DENOM_CAP + 1);          // denominator counter width
    localparam int PW   = nfs_pkg::VAL_W + DW;            // scaled product width
    localparam int QW   = PW - F + 1;                     // rounded numerator width
    localparam int MW   = F + DW;                         // cross product width
    localparam int LW   = (DW > nfs_pkg::DEN_W) ? DW : nfs_pkg::DEN_W;
    localparam int QXW  = (QW > nfs_pkg::NUM_W) ? QW : nfs_pkg::NUM_W + 1;
    localparam int EXW  = (F > nfs_pkg::ERR_W) ? F : nfs_pkg::ERR_W + 1;
    localparam int HALF = 1 << (F - 1);
    localparam int LIM_RST = (DENOM_CAP < nfs_pkg::LIMIT_RESET) ? DENOM_CAP
                                                                 : nfs_pkg::LIMIT_RESET;

    nfs_pkg::t_state r_state, n_state;

    logic [DW-1:0] r_limit;

    // search registers
    logic [nfs_pkg::VAL_W-1:0] r_mag;
    logic                      r_neg;
    logic [PW-1:0]             r_p;        // mag * d, built by repeated add
    logic [DW-1:0]             r_d;
    logic [QW-1:0]             r_best_q;
    logic [F-1:0]              r_best_r;
    logic [DW-1:0]             r_best_d;

    // output register
    logic                      r_out_valid;
    logic [nfs_pkg::NUM_W-1:0] r_num;
    logic [nfs_pkg::DEN_W-1:0] r_den;
    logic [nfs_pkg::ERR_W-1:0] r_err;

    logic                      w_accept;
    logic                      w_load;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [F-1:0]              w_quo;
    logic [nfs_pkg::VAL_W-1:0] w_mag;

    logic [F-1:0]  w_low;
    logic          w_up;
    logic [QW-1:0] w_q;
    logic [F-1:0]  w_r;
    logic [MW-1:0] w_lhs;
    logic [MW-1:0] w_rhs;
    logic          w_take;
    logic          w_last;

    logic [LW-1:0] w_cfg;
    logic [LW-1:0] w_cfg_clamp;

    logic [QXW-1:0]            w_qx;
    logic [QXW-1:0]            w_qs;
    logic [QXW-1:0]            w_qn;
    logic [nfs_pkg::NUM_W-1:0] w_num;
    logic [LW-1:0]             w_dx;
    logic [EXW-1:0]            w_ex;
    logic [nfs_pkg::ERR_W-1:0] w_err;

    assign w_accept = i_valid && !o_stall;

    // magnitude of the two's complement input; the most negative value maps to 2^31
    assign w_mag = i_ratio_value[nfs_pkg::VAL_W-1] ? (~i_ratio_value + nfs_pkg::VAL_W'(1))
                                                    : i_ratio_value;

    // round half away from zero on the magnitude: the fraction bits decide
    assign w_low = r_p[F-1:0];
    assign w_up  = w_low[F-1];
    assign w_q   = QW'(r_p[PW-1:F]) + QW'(w_up);
    // residual is the distance to the nearest multiple of one
    assign w_r   = w_up ? (~w_low + F'(1)) : w_low;

    // compare r/d against best_r/best_d without dividing
    assign w_lhs  = MW'(w_r) * MW'(r_best_d);
    assign w_rhs  = MW'(r_best_r) * MW'(r_d);
    assign w_take = (r_d == DW'(1)) || (w_lhs < w_rhs);
    assign w_last = (r_d == r_limit);

    // limit write clamp to 1..DENOM_CAP
    assign w_cfg = LW'(i_cfg_wr_data);
    always_comb begin
        priority if (w_cfg == '0) begin
            w_cfg_clamp = LW'(1);
        end else if (w_cfg > LW'(DENOM_CAP)) begin
            w_cfg_clamp = LW'(DENOM_CAP);
        end else begin
            w_cfg_clamp = w_cfg;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            nfs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = nfs_pkg::S_SEARCH;
                end
            end
            nfs_pkg::S_SEARCH: begin
                if (w_last) begin
                    n_state = nfs_pkg::S_DIV_START;
                end
            end
            nfs_pkg::S_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = nfs_pkg::S_DIV_WAIT;
            end
            nfs_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = nfs_pkg::S_DONE;
                end
            end
            nfs_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = nfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != nfs_pkg::S_IDLE);
    assign w_load  = (r_state == nfs_pkg::S_DONE) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfs_pkg::S_IDLE;
            r_limit     <= DW'(LIM_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= w_cfg_clamp[DW-1:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search datapath: one denominator per cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg    <= i_ratio_value[nfs_pkg::VAL_W-1];
            r_mag    <= w_mag;
            r_p      <= PW'(w_mag);
            r_d      <= DW'(1);
            r_best_q <= '0;
            r_best_r <= '0;
            r_best_d <= DW'(1);
        end else if (r_state == nfs_pkg::S_SEARCH) begin
            r_p <= r_p + PW'(r_mag);
            r_d <= r_d + DW'(1);
            if (w_take) begin
                r_best_q <= w_q;
                r_best_r <= w_r;
                r_best_d <= r_d;
            end
        end
    end

    // error = best residual / best denominator, one bit per cycle
    nfs_div #(
        .FRAC_BITS (F),
        .DW        (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_best_r),
        .i_divisor  (r_best_d),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // numerator: saturate the magnitude, then apply the sign
    assign w_qx = QXW'(r_best_q);
    assign w_qs = (w_qx > QXW'(nfs_pkg::NUM_NEG_MAX)) ? QXW'(nfs_pkg::NUM_NEG_MAX) : w_qx;
    assign w_qn = ~w_qs + QXW'(1);
    always_comb begin
        if (r_neg) begin
            w_num = w_qn[nfs_pkg::NUM_W-1:0];
        end else if (w_qx > QXW'(nfs_pkg::NUM_POS_MAX)) begin
            w_num = nfs_pkg::NUM_W'(nfs_pkg::NUM_POS_MAX);
        end else begin
            w_num = w_qx[nfs_pkg::NUM_W-1:0];
        end
    end

    // denominator field keeps the low bits of d
    assign w_dx = LW'(r_best_d);

    // error saturates at the field maximum
    assign w_ex  = EXW'(w_quo);
    assign w_err = (w_ex > EXW'(nfs_pkg::ERR_MAX)) ? nfs_pkg::ERR_W'(nfs_pkg::ERR_MAX)
                                                   : w_ex[nfs_pkg::ERR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_num <= w_num;
            r_den <= w_dx[nfs_pkg::DEN_W-1:0];
            r_err <= w_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_numerator    = r_num;
    assign o_denominator  = r_den;
    assign o_approx_error = r_err;

    `NFS_ASSERT(a_limit_range, (r_limit != '0) && (r_limit <= DW'(DENOM_CAP)),
                "limit out of range")
    `NFS_ASSERT_NEXT(a_accept_starts, w_accept,
                     (r_state == nfs_pkg::S_SEARCH) && (r_d == DW'(1)),
                     "search did not start at d of one")
    `NFS_ASSERT(a_search_order,
                (r_state != nfs_pkg::S_SEARCH) || ((r_d <= r_limit) && (r_best_d <= r_d)),
                "search denominator order broken")
    `NFS_ASSERT(a_best_half, (r_state != nfs_pkg::S_SEARCH) || (r_best_r <= F'(HALF)),
                "best residual above one half")
    `NFS_ASSERT_NEXT(a_load_shows, w_load, o_valid, "loaded word not presented")

endmodule
